FILE: rtl/amge_pkg.sv
// ----------------------------------------------------------------------------
// amge_pkg
// Shared types and constants of the adjacency matrix graph engine.
// ----------------------------------------------------------------------------
package amge_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int VERT_W       = $clog2(MAX_VERTICES);
   localparam int CNT_W        = VERT_W + 1;
   localparam int ACT_W        = 4;

   localparam logic [ACT_W-1:0] ACT_NEW_GRAPH   = 4'd0;
   localparam logic [ACT_W-1:0] ACT_ADD_EDGE    = 4'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVE_EDGE = 4'd2;
   localparam logic [ACT_W-1:0] ACT_COMPLEMENT  = 4'd3;
   localparam logic [ACT_W-1:0] ACT_REACH       = 4'd4;
   localparam logic [ACT_W-1:0] ACT_NEW_SECOND  = 4'd5;
   localparam logic [ACT_W-1:0] ACT_SECOND_EDGE = 4'd6;
   localparam logic [ACT_W-1:0] ACT_UNION       = 4'd7;
   localparam logic [ACT_W-1:0] ACT_INTERSECT   = 4'd8;

   typedef logic [MAX_VERTICES-1:0] row_type;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_SET_BIT,
      OP_CLR_BIT,
      OP_COMPLEMENT,
      OP_OR,
      OP_AND
   } row_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_EDGE_A,
      ST_EDGE_B,
      ST_ROWS,
      ST_REACH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              main_we;
      logic              sec_we;
      row_op_type        op;
      logic [VERT_W-1:0] row;
      logic [VERT_W-1:0] col;
      row_type           mask;
   } row_ctl_type;

   function automatic row_type onehot(input logic [VERT_W-1:0] idx);
      row_type r;
      r = '0;
      r[idx] = 1'b1;
      return r;
   endfunction

   function automatic row_type count_mask(input logic [CNT_W-1:0] n);
      row_type r;
      for (int j = 0; j < MAX_VERTICES; j++) begin
         r[j] = (CNT_W'(j) < n);
      end
      return r;
   endfunction

endpackage

FILE: rtl/amge_store.sv
// ----------------------------------------------------------------------------
// amge_store
// Row store of both matrices with the shared row update unit.
// ----------------------------------------------------------------------------
module amge_store (
   input  logic                  clock,
   input  logic                  reset,
   input  amge_pkg::row_ctl_type ctl,
   output amge_pkg::row_type     rd_row
);
   import amge_pkg::*;

   row_type main_ff [MAX_VERTICES];
   row_type sec_ff  [MAX_VERTICES];
   row_type main_row;
   row_type sec_row;
   row_type cur_row;
   row_type new_row;

   assign main_row = main_ff[ctl.row];
   assign sec_row  = sec_ff[ctl.row];
   assign rd_row   = main_row;
   assign cur_row  = ctl.sec_we ? sec_row : main_row;

   always_comb begin
      case (ctl.op)
         OP_CLEAR:      new_row = '0;
         OP_SET_BIT:    new_row = cur_row | onehot(ctl.col);
         OP_CLR_BIT:    new_row = cur_row & ~onehot(ctl.col);
         OP_COMPLEMENT: new_row = (main_row ^ ctl.mask) & ~onehot(ctl.row);
         OP_OR:         new_row = main_row | sec_row;
         OP_AND:        new_row = main_row & sec_row;
         default:       new_row = cur_row;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VERTICES; i++) begin
            main_ff[i] <= '0;
            sec_ff[i]  <= '0;
         end
      end else begin
         if (ctl.main_we) begin
            main_ff[ctl.row] <= new_row;
         end
         if (ctl.sec_we) begin
            sec_ff[ctl.row] <= new_row;
         end
      end
   end

endmodule

FILE: rtl/adjacency_matrix_graph_engine_unit.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_engine_unit
// Graph engine over a bit adjacency matrix and a second operand matrix.
// ----------------------------------------------------------------------------
// Every accepted command gives exactly one result, strobed by rsp_valid for
// one cycle; the receiver cannot stall it. Busy stays high from the transfer
// until the result cycle. The block updates or reads one matrix row per cycle
// through a single row unit: a new graph or second matrix, complement, union or
// intersection walks all 32 rows, an edge update writes the rows of both of its
// vertices, a reachability query reads the row of one vertex per expansion,
// and a rejected or unused command goes straight to the result state.
module adjacency_matrix_graph_engine_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [amge_pkg::ACT_W-1:0]      req_action,
   input  logic [amge_pkg::VERT_W-1:0]     req_vertex_a,
   input  logic [amge_pkg::VERT_W-1:0]     req_vertex_b,
   input  logic [amge_pkg::CNT_W-1:0]      req_vertex_count,
   output logic                            rsp_valid,
   output logic                            rsp_reachable,
   output logic                            rsp_error
);
   import amge_pkg::*;

   state_type         state_ff, state_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [VERT_W-1:0] a_ff, a_in;
   logic [VERT_W-1:0] b_ff, b_in;
   logic [VERT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  active_ff, active_in;
   logic [CNT_W-1:0]  second_ff, second_in;
   row_type           visited_ff, visited_in;
   row_type           frontier_ff, frontier_in;
   logic              reach_ff, reach_in;
   logic              err_ff, err_in;

   row_ctl_type       ctl;
   row_type           rd_row;
   logic [VERT_W-1:0] pick;
   logic [CNT_W-1:0]  clamped;
   logic [CNT_W-1:0]  grown;
   logic              last_row;

   amge_store u_store (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .rd_row (rd_row)
   );

   always_comb begin
      pick = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (frontier_ff[i]) begin
            pick = VERT_W'(i);
         end
      end
   end

   assign clamped  = (req_vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                                : req_vertex_count;
   assign grown    = (second_ff > active_ff) ? second_ff : active_ff;
   assign last_row = (idx_ff == VERT_W'(MAX_VERTICES - 1));

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_DONE);
   assign rsp_reachable = reach_ff;
   assign rsp_error     = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         act_ff      <= '0;
         a_ff        <= '0;
         b_ff        <= '0;
         idx_ff      <= '0;
         active_ff   <= '0;
         second_ff   <= '0;
         visited_ff  <= '0;
         frontier_ff <= '0;
         reach_ff    <= 1'b0;
         err_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         act_ff      <= act_in;
         a_ff        <= a_in;
         b_ff        <= b_in;
         idx_ff      <= idx_in;
         active_ff   <= active_in;
         second_ff   <= second_in;
         visited_ff  <= visited_in;
         frontier_ff <= frontier_in;
         reach_ff    <= reach_in;
         err_ff      <= err_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      idx_in      = idx_ff;
      active_in   = active_ff;
      second_in   = second_ff;
      visited_in  = visited_ff;
      frontier_in = frontier_ff;
      reach_in    = reach_ff;
      err_in      = err_ff;

      ctl.main_we = 1'b0;
      ctl.sec_we  = 1'b0;
      ctl.op      = OP_CLEAR;
      ctl.row     = idx_ff;
      ctl.col     = b_ff;
      ctl.mask    = count_mask(active_ff);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in   = req_action;
               a_in     = req_vertex_a;
               b_in     = req_vertex_b;
               idx_in   = '0;
               reach_in = 1'b0;
               err_in   = 1'b0;
               state_in = ST_DONE;
               case (req_action)
                  ACT_NEW_GRAPH: begin
                     active_in = clamped;
                     state_in  = ST_CLEAR;
                  end
                  ACT_NEW_SECOND: begin
                     second_in = clamped;
                     state_in  = ST_CLEAR;
                  end
                  ACT_ADD_EDGE, ACT_REMOVE_EDGE: begin
                     if ({1'b0, req_vertex_a} >= active_ff ||
                         {1'b0, req_vertex_b} >= active_ff) begin
                        err_in = 1'b1;
                     end else begin
                        state_in = ST_EDGE_A;
                     end
                  end
                  ACT_SECOND_EDGE: begin
                     if ({1'b0, req_vertex_a} >= second_ff ||
                         {1'b0, req_vertex_b} >= second_ff) begin
                        err_in = 1'b1;
                     end else begin
                        state_in = ST_EDGE_A;
                     end
                  end
                  ACT_COMPLEMENT: begin
                     state_in = ST_ROWS;
                  end
                  ACT_UNION, ACT_INTERSECT: begin
                     active_in = grown;
                     state_in  = ST_ROWS;
                  end
                  ACT_REACH: begin
                     if ({1'b0, req_vertex_a} >= active_ff ||
                         {1'b0, req_vertex_b} >= active_ff) begin
                        err_in = 1'b1;
                     end else begin
                        visited_in  = onehot(req_vertex_a);
                        frontier_in = onehot(req_vertex_a);
                        state_in    = ST_REACH;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            ctl.op      = OP_CLEAR;
            ctl.main_we = (act_ff == ACT_NEW_GRAPH);
            ctl.sec_we  = (act_ff != ACT_NEW_GRAPH);
            idx_in      = idx_ff + 1'b1;
            if (last_row) begin
               state_in = ST_DONE;
            end
         end
         ST_EDGE_A, ST_EDGE_B: begin
            ctl.row     = (state_ff == ST_EDGE_A) ? a_ff : b_ff;
            ctl.col     = (state_ff == ST_EDGE_A) ? b_ff : a_ff;
            ctl.op      = (act_ff == ACT_REMOVE_EDGE) ? OP_CLR_BIT : OP_SET_BIT;
            ctl.main_we = (act_ff != ACT_SECOND_EDGE);
            ctl.sec_we  = (act_ff == ACT_SECOND_EDGE);
            state_in    = (state_ff == ST_EDGE_A) ? ST_EDGE_B : ST_DONE;
         end
         ST_ROWS: begin
            case (act_ff)
               ACT_UNION: begin
                  ctl.op      = OP_OR;
                  ctl.main_we = 1'b1;
               end
               ACT_INTERSECT: begin
                  ctl.op      = OP_AND;
                  ctl.main_we = 1'b1;
               end
               default: begin
                  ctl.op      = OP_COMPLEMENT;
                  ctl.main_we = ({1'b0, idx_ff} < active_ff);
               end
            endcase
            idx_in = idx_ff + 1'b1;
            if (last_row) begin
               state_in = ST_DONE;
            end
         end
         ST_REACH: begin
            ctl.row = pick;
            if (visited_ff[b_ff]) begin
               reach_in = 1'b1;
               state_in = ST_DONE;
            end else if (frontier_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               visited_in  = visited_ff | rd_row;
               frontier_in = (frontier_ff & ~onehot(pick)) | (rd_row & ~visited_ff);
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
